@@ sv/assert_macros.svh @@
// assertion macros for the top level rtl file
// no dependencies; included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ sv/lsvm_pkg.sv @@
// shared types and constants for the looping sample voice mixer
// no dependencies; used by every module of the block except the ram
`timescale 1ns / 1ps
`default_nettype none

package lsvm_pkg;

   // sample store geometry
   localparam int MAX_FRAMES = 4096;
   localparam int POS_W      = $clog2(MAX_FRAMES);
   localparam int FRAMES_W   = 17;          // holds any frame count up to 65536

   // field widths
   localparam int MODE_W   = 2;
   localparam int ADDR_W   = 12;
   localparam int SAMPLE_W = 16;
   localparam int MIX_W    = 24;
   localparam int VOL_W    = 16;
   localparam int TOTAL_W  = 13;
   localparam int LOOPS_W  = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   // item kinds carried on req_tuser
   localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_START = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MIX   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MUTED         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_STEREO = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ENGINE_STEREO = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_FRAMES  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_COUNT    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_FOREVER  = 3'd6;

   // register reset values
   localparam logic [VOL_W-1:0]   VOLUME_RST = 16'd32768;
   localparam logic [TOTAL_W-1:0] TOTAL_RST  = 13'd4096;
   localparam logic [LOOPS_W-1:0] LOOPS_RST  = 16'd1;

   // playback status reported with each result
   typedef struct packed {
      logic               playing;
      logic [LOOPS_W-1:0] loops_left;
      logic               restarted;
      logic               finished;
   } stat_type;

endpackage

`default_nettype wire

@@ sv/lsvm_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies; holds the sample store
`timescale 1ns / 1ps
`default_nettype none

module lsvm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/lsvm_ctrl.sv @@
// playback sequencer: frame position, loop counter and active flag
// depends on lsvm_pkg
`timescale 1ns / 1ps
`default_nettype none

module lsvm_ctrl (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            fire,
   input  wire logic [lsvm_pkg::MODE_W-1:0]     mode,
   input  wire logic [lsvm_pkg::TOTAL_W-1:0]    total_frames,
   input  wire logic [lsvm_pkg::LOOPS_W-1:0]    loop_count,
   input  wire logic                            loop_forever,
   output logic      [lsvm_pkg::POS_W-1:0]      rd_addr,
   output logic                                 mix_go,
   output lsvm_pkg::stat_type                   stat
);

   logic [lsvm_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic [lsvm_pkg::LOOPS_W-1:0]  loops_ff, loops_in;
   logic                          active_ff, active_in;
   logic [lsvm_pkg::FRAMES_W-1:0] frames;
   logic [lsvm_pkg::FRAMES_W-1:0] pos_next;
   logic                          restarted, finished;

   // clamp frame count to 1..MAX_FRAMES
   always_comb begin
      if (total_frames == '0) begin
         frames = lsvm_pkg::FRAMES_W'(1);
      end else if (lsvm_pkg::FRAMES_W'(total_frames) >
                   lsvm_pkg::FRAMES_W'(lsvm_pkg::MAX_FRAMES)) begin
         frames = lsvm_pkg::FRAMES_W'(lsvm_pkg::MAX_FRAMES);
      end else begin
         frames = lsvm_pkg::FRAMES_W'(total_frames);
      end
   end

   assign pos_next = lsvm_pkg::FRAMES_W'(pos_ff) + lsvm_pkg::FRAMES_W'(1);
   assign mix_go   = fire && (mode == lsvm_pkg::MODE_MIX) && active_ff;

   always_comb begin
      pos_in    = pos_ff;
      loops_in  = loops_ff;
      active_in = active_ff;
      restarted = 1'b0;
      finished  = 1'b0;
      if (fire) begin
         unique case (mode)
            lsvm_pkg::MODE_START: begin
               pos_in    = '0;
               loops_in  = (loop_count == '0) ? lsvm_pkg::LOOPS_W'(1) : loop_count;
               active_in = 1'b1;
            end
            lsvm_pkg::MODE_MIX: begin
               if (active_ff) begin
                  if (pos_next >= frames) begin
                     pos_in = '0;
                     if (loop_forever) begin
                        // endless wrap, count untouched
                     end else if (loops_ff > lsvm_pkg::LOOPS_W'(1)) begin
                        loops_in  = loops_ff - lsvm_pkg::LOOPS_W'(1);
                        restarted = 1'b1;
                     end else begin
                        loops_in  = '0;
                        active_in = 1'b0;
                        finished  = 1'b1;
                     end
                  end else begin
                     pos_in = pos_next[lsvm_pkg::POS_W-1:0];
                  end
               end
            end
            default: begin
               // load and unused kinds leave playback alone
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         loops_ff  <= '0;
         active_ff <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         loops_ff  <= loops_in;
         active_ff <= active_in;
      end
   end

   assign rd_addr         = pos_ff;
   assign stat.playing    = active_in;
   assign stat.loops_left = loops_in;
   assign stat.restarted  = restarted;
   assign stat.finished   = finished;

endmodule

`default_nettype wire

@@ sv/lsvm_lane.sv @@
// one mixing lane: gain multiply, registered product, rounding and saturating add
// depends on lsvm_pkg
`timescale 1ns / 1ps
`default_nettype none

module lsvm_lane (
   input  wire logic                                  clock,
   input  wire logic                                  ld,
   input  wire logic signed [lsvm_pkg::SAMPLE_W-1:0]  sample_a,
   input  wire logic signed [lsvm_pkg::SAMPLE_W-1:0]  sample_b,
   input  wire logic                                  use_b,
   input  wire logic                                  half,
   input  wire logic                                  gain_on,
   input  wire logic        [lsvm_pkg::VOL_W-1:0]     volume,
   input  wire logic signed [lsvm_pkg::MIX_W-1:0]     mix_in,
   output logic signed      [lsvm_pkg::MIX_W-1:0]     mix_out
);

   localparam int OPND_W = lsvm_pkg::SAMPLE_W + 1;
   localparam int PROD_W = 2 * OPND_W;
   localparam int SUM_W  = lsvm_pkg::MIX_W + 3;
   localparam logic signed [SUM_W-1:0] MIX_MAX = SUM_W'((1 <<< (lsvm_pkg::MIX_W - 1)) - 1);
   localparam logic signed [SUM_W-1:0] MIX_MIN = -SUM_W'(1 <<< (lsvm_pkg::MIX_W - 1));

   logic signed [OPND_W-1:0]            opnd;
   logic signed [OPND_W-1:0]            vol_s;
   logic signed [PROD_W-1:0]            prod_in, prod_ff;
   logic signed [lsvm_pkg::MIX_W-1:0]   mix_ff;
   logic                                half_ff;
   logic signed [PROD_W-1:0]            rnd;
   logic signed [SUM_W-1:0]             sum;

   // zero operand when the lane contributes nothing
   always_comb begin
      if (!gain_on) begin
         opnd = '0;
      end else if (use_b) begin
         opnd = OPND_W'(sample_a) + OPND_W'(sample_b);
      end else begin
         opnd = OPND_W'(sample_a);
      end
   end

   assign vol_s   = $signed({1'b0, volume});
   assign prod_in = PROD_W'(opnd) * PROD_W'(vol_s);

   always_ff @(posedge clock) begin
      if (ld) begin
         prod_ff <= prod_in;
         mix_ff  <= mix_in;
         half_ff <= half;
      end
   end

   // round half up, then saturating add into the mix
   always_comb begin
      if (half_ff) begin
         rnd = (prod_ff + PROD_W'(128)) >>> 8;
      end else begin
         rnd = (prod_ff + PROD_W'(64)) >>> 7;
      end
      sum = SUM_W'(rnd) + SUM_W'(mix_ff);
      if (sum > MIX_MAX) begin
         mix_out = MIX_MAX[lsvm_pkg::MIX_W-1:0];
      end else if (sum < MIX_MIN) begin
         mix_out = MIX_MIN[lsvm_pkg::MIX_W-1:0];
      end else begin
         mix_out = sum[lsvm_pkg::MIX_W-1:0];
      end
   end

endmodule

`default_nettype wire

@@ sv/looping_sample_voice_mixer.sv @@
// top level of the looping sample voice mixer: ports, registers, pipeline, merge
// depends on lsvm_pkg, lsvm_ram, lsvm_ctrl, lsvm_lane, assert_macros.svh
//
//  channel  | direction | handshake             | contents
//  ---------+-----------+-----------------------+--------------------------------------
//  req_     | in        | tvalid/tready         | tuser mode, tdata load frame and mix in
//  rsp_     | out       | tvalid/tready, tlast  | tdata mix out and status, tlast finished
//  csr_     | in        | wen, no wait          | index and data of one register
//
// one item per cycle sustained while results are taken; an item passes through the store
// read register, the register after each lane multiplier and the output register, in that order
// each stage moves when the next one is empty or moving, so items keep flowing while
// a finished result waits, until the three stages are full
// synchronous reset clears playback state and stage valids and restores register defaults;
// the sample store has no clearing pass, unloaded frames read as whatever the ram holds
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module looping_sample_voice_mixer (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // input channel
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // frame_address[11:0], sample_left[27:12], sample_right[43:28],
   // mix_in_left[67:44], mix_in_right[91:68], zero[95:92]
   input  wire logic [95:0]                          req_tdata,
   // mode[1:0]
   input  wire logic [lsvm_pkg::MODE_W-1:0]          req_tuser,
   // result channel
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // mix_out_left[23:0], mix_out_right[47:24], playing[48], loops_left[64:49],
   // loop_restarted[65], zero[71:66]
   output logic      [71:0]                          rsp_tdata,
   // finished
   output logic                                      rsp_tlast,
   // configuration port
   input  wire logic                                 csr_wen,
   input  wire logic [lsvm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [lsvm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int STORE_W = 2 * lsvm_pkg::SAMPLE_W;

   // configuration registers
   logic [lsvm_pkg::VOL_W-1:0]   volume_ff;
   logic                         muted_ff;
   logic                         sample_stereo_ff;
   logic                         engine_stereo_ff;
   logic [lsvm_pkg::TOTAL_W-1:0] total_frames_ff;
   logic [lsvm_pkg::LOOPS_W-1:0] loop_count_ff;
   logic                         loop_forever_ff;

   // unpacked input fields
   logic [lsvm_pkg::MODE_W-1:0]          in_mode;
   logic [lsvm_pkg::ADDR_W-1:0]          in_addr;
   logic [lsvm_pkg::SAMPLE_W-1:0]        in_left;
   logic [lsvm_pkg::SAMPLE_W-1:0]        in_right;
   logic signed [lsvm_pkg::MIX_W-1:0]    in_mix_l;
   logic signed [lsvm_pkg::MIX_W-1:0]    in_mix_r;

   // stage enables
   logic fire;
   logic s1_ld, s2_ld, o_ld;

   // stage 1: store read data, mix inputs, status
   logic                                 s1_valid_ff;
   logic                                 s1_mix_ff;
   logic signed [lsvm_pkg::MIX_W-1:0]    s1_mix_l_ff, s1_mix_r_ff;
   lsvm_pkg::stat_type                   s1_stat_ff;

   // stage 2: lane products, status
   logic                                 s2_valid_ff;
   lsvm_pkg::stat_type                   s2_stat_ff;

   // output register
   logic                                 rsp_valid_ff;
   logic signed [lsvm_pkg::MIX_W-1:0]    out_l_ff, out_r_ff;
   lsvm_pkg::stat_type                   out_stat_ff;

   logic                                 load_wr;
   logic [lsvm_pkg::POS_W-1:0]           rd_addr;
   logic [STORE_W-1:0]                   rd_word;
   logic                                 mix_go;
   lsvm_pkg::stat_type                   stat;

   logic signed [lsvm_pkg::SAMPLE_W-1:0] smp_l, smp_r;
   logic                                 s2m, m2s, gain_on;
   logic signed [lsvm_pkg::SAMPLE_W-1:0] right_src;
   logic signed [lsvm_pkg::MIX_W-1:0]    lane_l_out, lane_r_out;

   assign in_mode  = req_tuser;
   assign in_addr  = req_tdata[11:0];
   assign in_left  = req_tdata[27:12];
   assign in_right = req_tdata[43:28];
   assign in_mix_l = $signed(req_tdata[67:44]);
   assign in_mix_r = $signed(req_tdata[91:68]);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff        <= lsvm_pkg::VOLUME_RST;
         muted_ff         <= 1'b0;
         sample_stereo_ff <= 1'b0;
         engine_stereo_ff <= 1'b1;
         total_frames_ff  <= lsvm_pkg::TOTAL_RST;
         loop_count_ff    <= lsvm_pkg::LOOPS_RST;
         loop_forever_ff  <= 1'b0;
      end else if (csr_wen) begin
         unique case (csr_index)
            lsvm_pkg::CSR_VOLUME:        volume_ff        <= csr_wdata;
            lsvm_pkg::CSR_MUTED:         muted_ff         <= csr_wdata[0];
            lsvm_pkg::CSR_SAMPLE_STEREO: sample_stereo_ff <= csr_wdata[0];
            lsvm_pkg::CSR_ENGINE_STEREO: engine_stereo_ff <= csr_wdata[0];
            lsvm_pkg::CSR_TOTAL_FRAMES:  total_frames_ff  <= csr_wdata[lsvm_pkg::TOTAL_W-1:0];
            lsvm_pkg::CSR_LOOP_COUNT:    loop_count_ff    <= csr_wdata;
            lsvm_pkg::CSR_LOOP_FOREVER:  loop_forever_ff  <= csr_wdata[0];
            default: begin
               // unknown index, write dropped
            end
         endcase
      end
   end

   // each stage loads when it is empty or its successor loads
   assign o_ld       = !rsp_valid_ff || rsp_tready;
   assign s2_ld      = !s2_valid_ff || o_ld;
   assign s1_ld      = !s1_valid_ff || s2_ld;
   assign req_tready = s1_ld;
   assign fire       = req_tvalid && s1_ld;

   // load frames land in the store; addresses past the end are dropped
   assign load_wr = fire && (in_mode == lsvm_pkg::MODE_LOAD) &&
                    (32'(in_addr) < lsvm_pkg::MAX_FRAMES);

   lsvm_ram #(
      .WIDTH (STORE_W),
      .DEPTH (lsvm_pkg::MAX_FRAMES)
   ) u_store (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (lsvm_pkg::POS_W'(in_addr)),
      .wr_data ({in_right, in_left}),
      .rd_en   (s1_ld),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   lsvm_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .mode         (in_mode),
      .total_frames (total_frames_ff),
      .loop_count   (loop_count_ff),
      .loop_forever (loop_forever_ff),
      .rd_addr      (rd_addr),
      .mix_go       (mix_go),
      .stat         (stat)
   );

   // stage 1 registers, read data sits in the ram output register alongside
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ld) begin
         s1_valid_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ld) begin
         s1_mix_ff   <= mix_go;
         s1_mix_l_ff <= in_mix_l;
         s1_mix_r_ff <= in_mix_r;
         s1_stat_ff  <= stat;
      end
   end

   // lane routing for the four sample and engine channel cases
   assign smp_l     = $signed(rd_word[lsvm_pkg::SAMPLE_W-1:0]);
   assign smp_r     = $signed(rd_word[STORE_W-1:lsvm_pkg::SAMPLE_W]);
   assign s2m       = sample_stereo_ff && !engine_stereo_ff;
   assign m2s       = !sample_stereo_ff && engine_stereo_ff;
   assign gain_on   = s1_mix_ff && !muted_ff && (volume_ff != '0);
   assign right_src = m2s ? smp_l : smp_r;

   // left lane: straight, or the average of both channels for a stereo sample on a mono engine
   lsvm_lane u_lane_l (
      .clock    (clock),
      .ld       (s2_ld),
      .sample_a (smp_l),
      .sample_b (smp_r),
      .use_b    (s2m),
      .half     (s2m),
      .gain_on  (gain_on),
      .volume   (volume_ff),
      .mix_in   (s1_mix_l_ff),
      .mix_out  (lane_l_out)
   );

   // right lane: duplicated mono, stereo right, or plain pass-through
   lsvm_lane u_lane_r (
      .clock    (clock),
      .ld       (s2_ld),
      .sample_a (right_src),
      .sample_b (smp_r),
      .use_b    (1'b0),
      .half     (1'b0),
      .gain_on  (gain_on && (m2s || (sample_stereo_ff && engine_stereo_ff))),
      .volume   (volume_ff),
      .mix_in   (s1_mix_r_ff),
      .mix_out  (lane_r_out)
   );

   // stage 2 control
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ld) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ld) begin
         s2_stat_ff <= s1_stat_ff;
      end
   end

   // merge: both lane sums and the status into the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (o_ld) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (o_ld) begin
         out_l_ff    <= lane_l_out;
         out_r_ff    <= lane_r_out;
         out_stat_ff <= s2_stat_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = out_stat_ff.finished;
   assign rsp_tdata  = {6'b0, out_stat_ff.restarted, out_stat_ff.loops_left,
                        out_stat_ff.playing, out_r_ff, out_l_ff};

   // a wrap and an end of playback never fall on the same step
   `ASSERT_IMPLIES(a_wrap_xor_end, clock, reset, s1_valid_ff,
                   !(s1_stat_ff.restarted && s1_stat_ff.finished))

   // a start transfer leaves the voice playing with at least one loop armed
   `ASSERT_NEXT(a_start_arms, clock, reset,
                fire && (in_mode == lsvm_pkg::MODE_START),
                s1_stat_ff.playing && (s1_stat_ff.loops_left != '0))

   // input is refused only when all three stages hold items and the output stalls
   `ASSERT_IMPLIES(a_refuse_only_full, clock, reset, !req_tready,
                   s1_valid_ff && s2_valid_ff && rsp_valid_ff && !rsp_tready)

   // an end of playback always reports an idle voice with no loops left
   `ASSERT_IMPLIES(a_end_idle, clock, reset, rsp_valid_ff && out_stat_ff.finished,
                   !out_stat_ff.playing && (out_stat_ff.loops_left == '0))

endmodule

`default_nettype wire
